[hdl/tts_pkg.sv]
// Shared types and constants of the text token splitter.
package tts_pkg;

	// Scanner modes
	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_WORD    = 2'd1,
		MODE_QUOTE   = 2'd2,
		MODE_COMMENT = 2'd3
	} mode_t;

	// Token kinds
	localparam logic [1:0] KIND_WORD    = 2'd0;
	localparam logic [1:0] KIND_STRING  = 2'd1;
	localparam logic [1:0] KIND_NEWLINE = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_COMMENT_LENGTH = 2'd0;
	localparam logic [1:0] CFG_COMMENT_TEXT   = 2'd1;
	localparam logic [1:0] CFG_SKIP_NEWLINES  = 2'd2;

	// Character codes
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	// Result queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// One result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] offset;
		logic [16:0] length;
		logic [31:0] line;
		logic        run_end;
	} res_t;

	// Saturating newline counter step
	function automatic logic [31:0] sat_inc(input logic [31:0] n);
		return (n == 32'hFFFF_FFFF) ? n : n + 32'd1;
	endfunction

	// Pick a comment marker byte; bytes past the fourth read as zero
	function automatic logic [7:0] marker_byte(input logic [31:0] text, input logic [2:0] k);
		return 8'(text >> {k, 3'b000});
	endfunction

endpackage

[hdl/text_token_splitter.sv]
// Top level of the text token splitter: byte scanner, result queue, config registers.
//
// Usage:
//   Text bytes enter on the text channel (text_valid / text_stall), one item per
//   byte, final_byte marking the last byte of a buffer. Tokens leave on the token
//   channel (token_valid / token_stall) as kind, offset, length and line number;
//   run_end marks the last token caused by one text byte. Each text byte causes
//   zero, one or two tokens.
//   Configuration goes through cfg_valid / cfg_ready / cfg_index / cfg_data;
//   cfg_ready is always high. Write only while no tokens are outstanding.
//   Tokens are written to the result queue and presented from it oldest first.
//   Throughput: one text byte per cycle while text_stall is low. The scanner
//   updates its state on each accepted byte; the four-entry result queue takes
//   a byte whenever it has room for two tokens, so bytes that cause two tokens
//   drain at one token per cycle while the token channel is not stalled.
//   When the receiver stalls, queued tokens hold and text_stall rises once fewer
//   than two queue slots are free.
//   Reset clears the scanner state, the queue pointers and count and the
//   configuration registers to zero; no clearing pass is needed. Offsets and
//   line count restart after every final byte.
module text_token_splitter #(
	parameter int BUFFER_BYTES = 65536,
	parameter int COMMENT_MAX  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [1:0]  token_kind,
	output logic [15:0] token_offset,
	output logic [16:0] token_length,
	output logic [31:0] line_number,
	output logic        run_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import tts_pkg::*;

	localparam int POS_W = $clog2(BUFFER_BYTES + 1);
	localparam int ST_W  = $clog2(BUFFER_BYTES);
	localparam logic [POS_W:0]   END_LIM  = (POS_W + 1)'(BUFFER_BYTES);
	localparam logic [POS_W:0]   LAST_LIM = (POS_W + 1)'(BUFFER_BYTES - 1);
	localparam logic [POS_W-1:0] END_POS  = POS_W'(BUFFER_BYTES);
	localparam logic [ST_W-1:0]  LAST_POS = ST_W'(BUFFER_BYTES - 1);

	// Clip an end position to the buffer size
	function automatic logic [POS_W-1:0] cap_end(input logic [POS_W:0] x);
		return (x < END_LIM) ? POS_W'(x) : END_POS;
	endfunction

	// Clip a start position to the last byte of the buffer
	function automatic logic [ST_W-1:0] cap_start(input logic [POS_W:0] x);
		return (x < LAST_LIM) ? ST_W'(x) : LAST_POS;
	endfunction

	// Length between start and end, zero if end lies before start
	function automatic logic [POS_W-1:0] span(input logic [ST_W-1:0] s,
			input logic [POS_W-1:0] e);
		return (POS_W'(s) < e) ? e - POS_W'(s) : '0;
	endfunction

	// Build one result item
	function automatic res_t mk(input logic [1:0] kind, input logic [ST_W-1:0] off,
			input logic [POS_W-1:0] len, input logic [31:0] line);
		res_t r;
		r.kind    = kind;
		r.offset  = 16'(off);
		r.length  = 17'(len);
		r.line    = line;
		r.run_end = 1'b0;
		return r;
	endfunction

	// Configuration registers
	logic [2:0]  cfg_len_q;
	logic [31:0] cfg_text_q;
	logic        cfg_skip_q;

	// Scanner state
	mode_t             mode_q, mode_d;
	logic              crp_q, crp_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [ST_W-1:0]   start_q, start_d;
	logic [2:0]        mcnt_q, mcnt_d;
	logic              mposs_q, mposs_d;
	logic              bslash_q, bslash_d;
	logic [31:0]       lines_q, lines_d;

	// Scanner results for the current byte
	res_t              res_d [2];
	logic [1:0]        rcnt_d;
	logic              consumed;
	logic [2:0]        clen;
	logic [POS_W:0]    p_ext, p1_ext;
	logic [POS_W-1:0]  qlen;

	// Result queue
	res_t              q_mem [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push, pop;

	assign cfg_ready  = 1'b1;
	assign push       = text_valid && !text_stall;
	assign pop        = token_valid && !token_stall;
	assign text_stall = (count_q > (QPTR_W + 1)'(QDEPTH - 2));
	assign p_ext      = {1'b0, pos_q};
	assign p1_ext     = p_ext + (POS_W + 1)'(1);
	assign clen       = (int'(cfg_len_q) > COMMENT_MAX) ? 3'(COMMENT_MAX) : cfg_len_q;

	// Scan one byte: next state and up to two tokens
	always_comb begin
		mode_d   = mode_q;
		crp_d    = crp_q;
		pos_d    = pos_q;
		start_d  = start_q;
		mcnt_d   = mcnt_q;
		mposs_d  = mposs_q;
		bslash_d = bslash_q;
		lines_d  = lines_q;
		res_d[0] = '0;
		res_d[1] = '0;
		rcnt_d   = 2'd0;
		consumed = 1'b0;
		qlen     = '0;

		// Close a pending CR, folding in an LF
		if (crp_q) begin
			crp_d   = 1'b0;
			lines_d = sat_inc(lines_d);
			if (text_byte == CH_LF) begin
				consumed = 1'b1;
				if (!cfg_skip_q && !rcnt_d[1]) begin
					res_d[rcnt_d[0]] = mk(KIND_NEWLINE, start_d, POS_W'(2), lines_d);
					rcnt_d = rcnt_d + 2'd1;
				end
			end else if (!cfg_skip_q && !rcnt_d[1]) begin
				res_d[rcnt_d[0]] = mk(KIND_NEWLINE, start_d, POS_W'(1), lines_d);
				rcnt_d = rcnt_d + 2'd1;
			end
		end

		if (!consumed) begin
			// Leave a comment at line end
			if (mode_d == MODE_COMMENT && (text_byte == CH_CR || text_byte == CH_LF))
				mode_d = MODE_IDLE;
			// End a word at whitespace
			if (mode_d == MODE_WORD &&
					(text_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})) begin
				if (!rcnt_d[1]) begin
					res_d[rcnt_d[0]] = mk(KIND_WORD, start_d,
						span(start_d, cap_end(p_ext)), lines_d);
					rcnt_d = rcnt_d + 2'd1;
				end
				mode_d = MODE_IDLE;
			end

			case (mode_d)
				MODE_IDLE: begin
					case (text_byte)
						CH_SPACE, CH_TAB: begin
						end
						CH_CR: begin
							crp_d   = 1'b1;
							start_d = cap_start(p_ext);
						end
						CH_LF: begin
							lines_d = sat_inc(lines_d);
							if (!cfg_skip_q && !rcnt_d[1]) begin
								res_d[rcnt_d[0]] = mk(KIND_NEWLINE, cap_start(p_ext),
									POS_W'(1), lines_d);
								rcnt_d = rcnt_d + 2'd1;
							end
						end
						CH_QUOTE: begin
							mode_d   = MODE_QUOTE;
							start_d  = cap_start(p1_ext);
							bslash_d = 1'b0;
						end
						default: begin
							// Open a word, checking the first marker byte
							mode_d  = MODE_WORD;
							start_d = cap_start(p_ext);
							mcnt_d  = 3'd0;
							mposs_d = 1'b0;
							if (clen != 3'd0 &&
									text_byte == marker_byte(cfg_text_q, 3'd0)) begin
								mcnt_d  = 3'd1;
								mposs_d = 1'b1;
								if (clen == 3'd1) begin
									mposs_d = 1'b0;
									if (!final_byte)
										mode_d = MODE_COMMENT;
								end
							end
						end
					endcase
				end
				MODE_WORD: begin
					// Advance the marker match
					if (mposs_d) begin
						if (mcnt_d < clen && text_byte == marker_byte(cfg_text_q, mcnt_d)) begin
							mcnt_d = mcnt_d + 3'd1;
							if (mcnt_d == clen) begin
								mposs_d = 1'b0;
								if (!final_byte)
									mode_d = MODE_COMMENT;
							end
						end else begin
							mposs_d = 1'b0;
						end
					end
				end
				MODE_QUOTE: begin
					if (text_byte == CH_QUOTE && !bslash_d) begin
						qlen = span(start_d, cap_end(p_ext));
						if (qlen != '0 && !rcnt_d[1]) begin
							res_d[rcnt_d[0]] = mk(KIND_STRING, start_d, qlen, lines_d);
							rcnt_d = rcnt_d + 2'd1;
						end
						mode_d = MODE_IDLE;
					end else begin
						bslash_d = (text_byte == CH_BACKSLASH);
					end
				end
				default: begin
				end
			endcase
		end

		// Flush open tokens at the buffer end and restart
		if (final_byte) begin
			if (crp_d) begin
				lines_d = sat_inc(lines_d);
				if (!cfg_skip_q && !rcnt_d[1]) begin
					res_d[rcnt_d[0]] = mk(KIND_NEWLINE, start_d, POS_W'(1), lines_d);
					rcnt_d = rcnt_d + 2'd1;
				end
			end
			if (mode_d == MODE_WORD && !rcnt_d[1]) begin
				res_d[rcnt_d[0]] = mk(KIND_WORD, start_d,
					span(start_d, cap_end(p1_ext)), lines_d);
				rcnt_d = rcnt_d + 2'd1;
			end else if (mode_d == MODE_QUOTE && !rcnt_d[1]) begin
				res_d[rcnt_d[0]] = mk(KIND_ERROR, start_d,
					span(start_d, cap_end(p1_ext)), lines_d);
				rcnt_d = rcnt_d + 2'd1;
			end
			mode_d   = MODE_IDLE;
			crp_d    = 1'b0;
			pos_d    = '0;
			start_d  = '0;
			mcnt_d   = 3'd0;
			mposs_d  = 1'b0;
			bslash_d = 1'b0;
			lines_d  = 32'd0;
		end else begin
			pos_d = cap_end(p1_ext);
		end

		// Flag the last token of this byte
		if (rcnt_d == 2'd1)
			res_d[0].run_end = 1'b1;
		else if (rcnt_d == 2'd2)
			res_d[1].run_end = 1'b1;
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len_q  <= 3'd0;
			cfg_text_q <= 32'd0;
			cfg_skip_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COMMENT_LENGTH: cfg_len_q  <= cfg_data[2:0];
				CFG_COMMENT_TEXT:   cfg_text_q <= cfg_data;
				CFG_SKIP_NEWLINES:  cfg_skip_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Advance scanner state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			crp_q    <= 1'b0;
			pos_q    <= '0;
			start_q  <= '0;
			mcnt_q   <= 3'd0;
			mposs_q  <= 1'b0;
			bslash_q <= 1'b0;
			lines_q  <= 32'd0;
		end else if (push) begin
			mode_q   <= mode_d;
			crp_q    <= crp_d;
			pos_q    <= pos_d;
			start_q  <= start_d;
			mcnt_q   <= mcnt_d;
			mposs_q  <= mposs_d;
			bslash_q <= bslash_d;
			lines_q  <= lines_d;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + QPTR_W'(rcnt_d);
			if (pop)
				rptr_q <= rptr_q + QPTR_W'(1);
			count_q <= count_q + (push ? (QPTR_W + 1)'(rcnt_d) : '0)
				- (pop ? (QPTR_W + 1)'(1) : '0);
		end
	end

	// Store new tokens
	always_ff @(posedge clk) begin
		if (push && rcnt_d != 2'd0)
			q_mem[wptr_q] <= res_d[0];
		if (push && rcnt_d == 2'd2)
			q_mem[wptr_q + QPTR_W'(1)] <= res_d[1];
	end

	// Present the oldest token
	assign token_valid  = (count_q != '0);
	assign token_kind   = q_mem[rptr_q].kind;
	assign token_offset = q_mem[rptr_q].offset;
	assign token_length = q_mem[rptr_q].length;
	assign line_number  = q_mem[rptr_q].line;
	assign run_end      = q_mem[rptr_q].run_end;

endmodule

[hdl/tts_checker.sv]
// Port-level checks of the text token splitter and their binding.
module tts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        text_valid,
	input logic        text_stall,
	input logic [7:0]  text_byte,
	input logic        final_byte,
	input logic        token_valid,
	input logic        token_stall,
	input logic [1:0]  token_kind,
	input logic [15:0] token_offset,
	input logic [16:0] token_length,
	input logic [31:0] line_number,
	input logic        run_end,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [31:0] cfg_data
);
	import tts_pkg::*;

	// Hold a stalled token
	a_token_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(token_kind) &&
		$stable(token_offset) && $stable(token_length) && $stable(line_number) &&
		$stable(run_end))
		else $error("stalled token changed");

	// Stall input only while tokens are queued
	a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> token_valid)
		else $error("input stalled with empty queue");

	// Newline tokens are one or two bytes and counted
	a_newline_shape: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == KIND_NEWLINE |->
		(token_length == 17'd1 || token_length == 17'd2) && line_number != 32'd0)
		else $error("bad newline token");

	// Quoted strings are never empty
	a_string_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == KIND_STRING |-> token_length != 17'd0)
		else $error("empty string token");

	// A token that leaves the run open is followed by another token
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_stall && !run_end |=> token_valid)
		else $error("run ended without closing token");

endmodule

bind text_token_splitter tts_checker u_tts_checker (.*);

[tb/tts_token_checker.sv]
`timescale 1ns / 100ps
// Token checker for the text token splitter: predicts tokens from accepted bytes and compares.
module tts_token_checker #(
	parameter int BUFFER_BYTES = 65536,
	parameter int COMMENT_MAX  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	input  logic        text_stall,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	input  logic        token_valid,
	input  logic        token_stall,
	input  logic [1:0]  token_kind,
	input  logic [15:0] token_offset,
	input  logic [16:0] token_length,
	input  logic [31:0] line_number,
	input  logic        run_end,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatch_count,
	output int          outstanding
);
	import tts_pkg::*;

	// Scanner state
	mode_t       scan_mode;
	logic        cr_pending;
	logic [16:0] position;
	logic [15:0] token_start;
	logic [2:0]  match_count;
	logic        match_live;
	logic        after_backslash;
	logic [31:0] line_count;

	// Register copies
	logic [2:0]  marker_len_reg;
	logic [31:0] marker_text;
	logic        newline_skip;

	// Tokens still owed by the block, oldest first
	res_t        expected_tokens[$];
	res_t        byte_tokens[2];
	int          byte_token_count;
	int          errors;

	function automatic logic [16:0] clip_end(input int unsigned p);
		return (p < BUFFER_BYTES) ? 17'(p) : 17'(BUFFER_BYTES);
	endfunction

	function automatic logic [15:0] clip_start(input int unsigned p);
		return (p < BUFFER_BYTES - 1) ? 16'(p) : 16'(BUFFER_BYTES - 1);
	endfunction

	function automatic logic [16:0] token_span(input int unsigned s, input int unsigned e);
		return (e > s) ? 17'(e - s) : 17'd0;
	endfunction

	// Bytes past the fourth read as zero
	function automatic logic [7:0] marker_at(input int k);
		return (k < 4) ? marker_text[8*k +: 8] : 8'h00;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
	endfunction

	// Hold at most two tokens per byte
	task automatic add_token(input logic [1:0] kind, input logic [15:0] off,
			input logic [16:0] len);
		res_t t;
		t.kind    = kind;
		t.offset  = off;
		t.length  = len;
		t.line    = line_count;
		t.run_end = 1'b0;
		if (byte_token_count < 2) begin
			byte_tokens[byte_token_count] = t;
			byte_token_count++;
		end
	endtask

	// Count a line (saturating) and report it unless suppressed
	task automatic count_newline(input logic [15:0] start, input logic [16:0] len);
		if (line_count != 32'hFFFF_FFFF)
			line_count++;
		if (!newline_skip)
			add_token(KIND_NEWLINE, start, len);
	endtask

	// Advance the scanner by one byte and queue the tokens it causes
	task automatic scan_byte(input logic [7:0] b, input logic fin);
		int unsigned p;
		int          mlen;
		logic        taken;
		logic [16:0] len;
		p = position;
		mlen = (int'(marker_len_reg) < COMMENT_MAX) ? int'(marker_len_reg) : COMMENT_MAX;
		taken = 1'b0;
		byte_token_count = 0;

		// Close a pending CR, folding in a following LF
		if (cr_pending) begin
			cr_pending = 1'b0;
			if (b == CH_LF) begin
				count_newline(token_start, 17'd2);
				taken = 1'b1;
			end else begin
				count_newline(token_start, 17'd1);
			end
		end

		if (!taken) begin
			if (scan_mode == MODE_COMMENT && (b == CH_CR || b == CH_LF))
				scan_mode = MODE_IDLE;
			if (scan_mode == MODE_WORD && is_blank(b)) begin
				add_token(KIND_WORD, token_start, token_span(token_start, clip_end(p)));
				scan_mode = MODE_IDLE;
			end
			case (scan_mode)
				MODE_IDLE: begin
					case (b)
						CH_SPACE, CH_TAB: ;
						CH_CR: begin
							cr_pending = 1'b1;
							token_start = clip_start(p);
						end
						CH_LF: count_newline(clip_start(p), 17'd1);
						CH_QUOTE: begin
							scan_mode = MODE_QUOTE;
							token_start = clip_start(p + 1);
							after_backslash = 1'b0;
						end
						default: begin
							scan_mode = MODE_WORD;
							token_start = clip_start(p);
							match_count = 3'd0;
							match_live = 1'b0;
							if (mlen > 0 && b == marker_at(0)) begin
								match_count = 3'd1;
								match_live = 1'b1;
								if (mlen == 1) begin
									match_live = 1'b0;
									if (!fin)
										scan_mode = MODE_COMMENT;
								end
							end
						end
					endcase
				end
				MODE_WORD: begin
					// Track the comment marker at the head of the word
					if (match_live) begin
						if (int'(match_count) < mlen && b == marker_at(match_count)) begin
							match_count++;
							if (int'(match_count) == mlen) begin
								match_live = 1'b0;
								if (!fin)
									scan_mode = MODE_COMMENT;
							end
						end else begin
							match_live = 1'b0;
						end
					end
				end
				MODE_QUOTE: begin
					if (b == CH_QUOTE && !after_backslash) begin
						len = token_span(token_start, clip_end(p));
						if (len != 17'd0)
							add_token(KIND_STRING, token_start, len);
						scan_mode = MODE_IDLE;
					end else begin
						after_backslash = (b == CH_BACKSLASH);
					end
				end
				default: ;
			endcase
		end

		// Flush open tokens at the end of the buffer and restart
		if (fin) begin
			if (cr_pending)
				count_newline(token_start, 17'd1);
			if (scan_mode == MODE_WORD)
				add_token(KIND_WORD, token_start, token_span(token_start, clip_end(p + 1)));
			else if (scan_mode == MODE_QUOTE)
				add_token(KIND_ERROR, token_start, token_span(token_start, clip_end(p + 1)));
			scan_mode = MODE_IDLE;
			cr_pending = 1'b0;
			position = 17'd0;
			token_start = 16'd0;
			match_count = 3'd0;
			match_live = 1'b0;
			after_backslash = 1'b0;
			line_count = 32'd0;
		end else begin
			position = clip_end(p + 1);
		end

		for (int i = 0; i < byte_token_count; i++) begin
			byte_tokens[i].run_end = (i == byte_token_count - 1);
			expected_tokens.push_back(byte_tokens[i]);
		end
	endtask

	// Compare one accepted token with the oldest expectation
	task automatic check_token();
		res_t got;
		res_t want;
		got.kind    = token_kind;
		got.offset  = token_offset;
		got.length  = token_length;
		got.line    = line_number;
		got.run_end = run_end;
		if (expected_tokens.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: token with none expected: kind %0d off %0d len %0d line %0d end %0b",
					$time, got.kind, got.offset, got.length, got.line, got.run_end);
		end else begin
			want = expected_tokens.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: token mismatch", $time);
					$display("  expected kind %0d off %0d len %0d line %0d end %0b",
						want.kind, want.offset, want.length, want.line, want.run_end);
					$display("  actual   kind %0d off %0d len %0d line %0d end %0b",
						got.kind, got.offset, got.length, got.line, got.run_end);
				end
			end
		end
	endtask

	// Watch the three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode = MODE_IDLE;
			cr_pending = 1'b0;
			position = 17'd0;
			token_start = 16'd0;
			match_count = 3'd0;
			match_live = 1'b0;
			after_backslash = 1'b0;
			line_count = 32'd0;
			marker_len_reg = 3'd0;
			marker_text = 32'd0;
			newline_skip = 1'b0;
			expected_tokens.delete();
			errors = 0;
			mismatch_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_COMMENT_LENGTH: marker_len_reg = cfg_data[2:0];
					CFG_COMMENT_TEXT:   marker_text = cfg_data;
					CFG_SKIP_NEWLINES:  newline_skip = cfg_data[0];
					default: ;
				endcase
			end
			if (text_valid && !text_stall)
				scan_byte(text_byte, final_byte);
			if (token_valid && !token_stall)
				check_token();
			mismatch_count <= errors;
			outstanding <= expected_tokens.size();
		end
	end

endmodule

[tb/tb_text_token_splitter.sv]
`timescale 1ns / 100ps
// Testbench top of the text token splitter: clock, reset, stimulus and verdict.
module tb_text_token_splitter;
	import tts_pkg::*;

	localparam int BUFFER_BYTES = 65536;
	localparam int COMMENT_MAX  = 4;
	localparam int STALL_LIMIT  = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        text_valid = 1'b0;
	logic        text_stall;
	logic [7:0]  text_byte = 8'h00;
	logic        final_byte = 1'b0;
	logic        token_valid;
	logic        token_stall = 1'b0;
	logic [1:0]  token_kind;
	logic [15:0] token_offset;
	logic [16:0] token_length;
	logic [31:0] line_number;
	logic        run_end;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_COMMENT_LENGTH;
	logic [31:0] cfg_data = 32'h0;

	int          mismatch_count;
	int          outstanding;
	int          idle_cycles = 0;
	bit          steady = 1'b0;
	logic [2:0]  cur_len = 3'd0;
	logic [31:0] cur_text = 32'h0;
	logic [7:0]  text_q[$];

	text_token_splitter #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.COMMENT_MAX (COMMENT_MAX)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text_byte   (text_byte),
		.final_byte  (final_byte),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_kind  (token_kind),
		.token_offset(token_offset),
		.token_length(token_length),
		.line_number (line_number),
		.run_end     (run_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	tts_token_checker #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.COMMENT_MAX (COMMENT_MAX)
	) token_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_valid    (text_valid),
		.text_stall    (text_stall),
		.text_byte     (text_byte),
		.final_byte    (final_byte),
		.token_valid   (token_valid),
		.token_stall   (token_stall),
		.token_kind    (token_kind),
		.token_offset  (token_offset),
		.token_length  (token_length),
		.line_number   (line_number),
		.run_end       (run_end),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the token channel at random, but never while steady is set
	always @(negedge clk) begin
		token_stall <= steady ? 1'b0 : ($urandom_range(99) < 34);
	end

	// End the run when no channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && !text_stall) || (token_valid && !token_stall) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offer one byte, idling at random, and hold it until taken
	task automatic push_byte(input logic [7:0] b, input logic fin);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 34) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		final_byte <= fin;
		do @(posedge clk); while (text_stall);
	endtask

	// Hold off input until every token has come and the block has settled
	task automatic drain();
		@(negedge clk);
		text_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [2:0] len, input logic [31:0] txt, input logic skip);
		drain();
		write_reg(CFG_COMMENT_LENGTH, {29'd0, len});
		write_reg(CFG_COMMENT_TEXT, txt);
		write_reg(CFG_SKIP_NEWLINES, {31'd0, skip});
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_len = len;
		cur_text = txt;
	endtask

	task automatic add_byte(input logic [7:0] b);
		text_q.push_back(b);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// Send the buffer, flagging its last byte
	task automatic send_buffer();
		for (int i = 0; i < text_q.size(); i++)
			push_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	function automatic logic [7:0] word_char();
		logic [7:0] c;
		do begin
			c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(126, 33));
		end while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_QUOTE);
		return c;
	endfunction

	// Append one piece of text: word, marker, quote, blanks, newline or noise
	task automatic add_piece();
		int         pick;
		int         m;
		int         n;
		logic [7:0] c;
		pick = $urandom_range(99);
		m = (cur_len > 3'd4) ? 4 : int'(cur_len);
		if (pick < 30 || (pick < 45 && m == 0)) begin
			repeat ($urandom_range(6, 1)) add_byte(word_char());
		end else if (pick < 45) begin
			n = $urandom_range(1) ? m : $urandom_range(m);
			for (int k = 0; k < n; k++)
				add_byte(cur_text[8*k +: 8]);
			if (n < m) begin
				add_byte(word_char());
			end else begin
				// comment body up to a line end
				repeat ($urandom_range(5)) begin
					do c = 8'($urandom_range(255)); while (c == CH_CR || c == CH_LF);
					add_byte(c);
				end
				add_byte($urandom_range(1) ? CH_LF : CH_CR);
			end
		end else if (pick < 60) begin
			add_byte(CH_QUOTE);
			repeat ($urandom_range(6)) begin
				if ($urandom_range(4) == 0) begin
					add_byte(CH_BACKSLASH);
					add_byte($urandom_range(1) ? CH_QUOTE : 8'($urandom_range(255)));
				end else begin
					do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
					add_byte(c);
				end
			end
			if ($urandom_range(9) != 0)
				add_byte(CH_QUOTE);
		end else if (pick < 75) begin
			repeat ($urandom_range(3, 1)) add_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
		end else if (pick < 90) begin
			case ($urandom_range(2))
				0: add_byte(CH_CR);
				1: add_byte(CH_LF);
				default: begin
					add_byte(CH_CR);
					add_byte(CH_LF);
				end
			endcase
		end else begin
			repeat ($urandom_range(4, 1)) add_byte(8'($urandom_range(255)));
		end
	endtask

	// Send random buffers until the byte budget is spent
	task automatic run_phase(input int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			repeat ($urandom_range(8, 1)) add_piece();
			sent += text_q.size();
			send_buffer();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Oversized marker length: extreme bytes, strings, CRLF, comment, bare CR
		set_config(3'd5, 32'h2525_2525, 1'b0);
		add_byte(8'hFF);
		add_byte(8'h00);
		add_str(" \"a\\\"\" \"\"\r\n\r%%%%x\t\n");
		send_buffer();
		// marker alone as the final word
		add_str("%%%%");
		send_buffer();
		// quote as first marker byte, then an open quote at the end
		set_config(3'd2, 32'h0000_2522, 1'b0);
		add_str("\"%\"\"");
		send_buffer();
		// whitespace inside the marker, then a CR at the end
		set_config(3'd2, 32'h0000_0925, 1'b0);
		add_str("%\t%\r");
		send_buffer();

		// Random phases over several settings
		set_config(3'd0, 32'h0000_0000, 1'b0);
		run_phase(135);
		set_config(3'd1, {24'h0, 8'($urandom_range(126, 33))}, 1'b1);
		run_phase(135);
		set_config(3'd2, 32'h0000_2F2F, 1'b0);
		steady = 1'b1;
		run_phase(200);
		steady = 1'b0;
		set_config(3'd4, 32'hFFFF_FFFF, 1'b1);
		run_phase(135);
		set_config(3'd7, $urandom, 1'b0);
		run_phase(135);
		set_config(3'd2, 32'h0000_2323, 1'b0);
		run_phase(135);

		set_config(3'($urandom_range(7)), $urandom, 1'($urandom_range(1)));
		run_phase(135);

		drain();
		if (mismatch_count == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
hdl/tts_pkg.sv
hdl/text_token_splitter.sv
hdl/tts_checker.sv
tb/tts_token_checker.sv
tb/tb_text_token_splitter.sv
